/* rtl/tpq_pkg.sv */
package tpq_pkg;

    // Operation codes carried by the op field of an input item.
    typedef enum logic [1:0] {
        OP_INSERT   = 2'd0,
        OP_SERVE    = 2'd1,
        OP_WITHDRAW = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch a new item and arm the scan
        logic scan;      // step the search over the queued entries
        logic decide;    // latch the result fields
        logic ok;        // success flag latched with decide
        logic dn_start;  // arm the close-up shift after a removal
        logic dn;        // step the close-up shift
        logic up_start;  // arm the open-up shift before an insertion
        logic up;        // step the open-up shift
        logic place;     // write the new entry and count it
        logic dec;       // count one entry fewer
        logic respond;   // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic found;
        logic empty;
        logic full;
        logic scan_done;
        logic dn_done;
        logic up_done;
        logic out_free;
    } t_stat;

endpackage

/* rtl/tpq_ram.sv */
module tpq_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one read port with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/tpq_datapath.sv */
module tpq_datapath #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_op,
    input  logic [15:0]    i_person_id,
    input  logic           i_preferred,
    input  logic           i_out_stall,
    input  tpq_pkg::t_cmd  i_cmd,
    output tpq_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output logic           o_ok,
    output logic [15:0]    o_served_id,
    output logic           o_is_preferred,
    output logic [4:0]     o_occupancy
);

    import tpq_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = ID_BITS + 1;

    // Latched item.
    t_op                r_op;
    logic [ID_BITS-1:0] r_id;
    logic               r_cls;

    // Queue occupancy.
    logic [CNT_W-1:0]   r_count;

    // Search state.
    logic [CNT_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_rd_pos;
    logic               r_scan_rd;
    logic               r_found;
    logic [CNT_W-1:0]   r_found_pos;
    logic               r_found_cls;
    logic               r_ord_seen;
    logic [CNT_W-1:0]   r_ord_pos;
    logic [ID_BITS-1:0] r_head;

    // Shift state.
    logic [CNT_W-1:0]   r_sh_ptr;
    logic [IDX_W-1:0]   r_sh_wa;
    logic               r_sh_rd;
    logic [CNT_W-1:0]   r_tgt;

    // Result and output registers.
    logic               r_res_ok;
    logic [ID_BITS-1:0] r_res_served;
    logic               r_res_pref;
    logic               r_out_valid;
    logic               r_o_ok;
    logic [15:0]        r_o_served;
    logic               r_o_pref;
    logic [4:0]         r_o_occ;

    // Memory port signals.
    logic               scan_issue;
    logic               dn_issue;
    logic               up_issue;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic [CNT_W-1:0]   up_ptr_m1;
    logic [CNT_W-1:0]   ins_pos;
    logic [CNT_W-1:0]   dn_base;
    logic [ID_BITS-1:0] rd_id;
    logic               rd_cls;
    logic               out_free;

    assign rd_id  = rd_data[ID_BITS-1:0];
    assign rd_cls = rd_data[ID_BITS];

    // Read requests: the search walks upwards, the close-up shift walks
    // upwards and the open-up shift walks downwards.
    assign up_ptr_m1  = r_sh_ptr - CNT_W'(1);
    assign scan_issue = i_cmd.scan && (r_rd_ptr != r_count);
    assign dn_issue   = i_cmd.dn && (r_sh_ptr != r_count);
    assign up_issue   = i_cmd.up && (r_sh_ptr != r_tgt);
    assign rd_en      = scan_issue || dn_issue || up_issue;

    always_comb begin
        if (scan_issue) begin
            rd_addr = r_rd_ptr[IDX_W-1:0];
        end else if (dn_issue) begin
            rd_addr = r_sh_ptr[IDX_W-1:0];
        end else begin
            rd_addr = up_ptr_m1[IDX_W-1:0];
        end
    end

    // Writes: the new entry, or an entry read in the previous cycle moved by one.
    always_comb begin
        if (i_cmd.place) begin
            wr_en   = 1'b1;
            wr_addr = r_tgt[IDX_W-1:0];
            wr_data = {r_cls, r_id};
        end else begin
            wr_en   = r_sh_rd;
            wr_addr = r_sh_wa;
            wr_data = rd_data;
        end
    end

    // A preferred id goes in front of the first ordinary one.
    assign ins_pos  = (r_cls && r_ord_seen) ? r_ord_pos : r_count;
    assign dn_base  = (r_op == OP_SERVE) ? {CNT_W{1'b0}} : r_found_pos;
    assign out_free = !r_out_valid || !i_out_stall;

    tpq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan_rd   <= 1'b0;
            r_sh_rd     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_scan_rd <= scan_issue;
            r_sh_rd   <= dn_issue || up_issue;
            if (i_cmd.place) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_cmd.dec) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (i_cmd.respond) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op       <= t_op'(i_op);
            r_id       <= ID_BITS'(i_person_id);
            r_cls      <= i_preferred;
            r_rd_ptr   <= '0;
            r_found    <= 1'b0;
            r_ord_seen <= 1'b0;
        end
        if (scan_issue) begin
            r_rd_ptr <= r_rd_ptr + CNT_W'(1);
            r_rd_pos <= r_rd_ptr;
        end

        // Examine each entry as it returns from the memory.
        if (r_scan_rd) begin
            if (!r_found && (rd_id == r_id)) begin
                r_found     <= 1'b1;
                r_found_pos <= r_rd_pos;
                r_found_cls <= rd_cls;
            end
            if (!r_ord_seen && !rd_cls) begin
                r_ord_seen <= 1'b1;
                r_ord_pos  <= r_rd_pos;
            end
            if (r_rd_pos == '0) begin
                r_head <= rd_id;
            end
        end

        // Shift pointers.
        if (i_cmd.dn_start) begin
            r_sh_ptr <= dn_base + CNT_W'(1);
        end else if (i_cmd.up_start) begin
            r_sh_ptr <= r_count;
            r_tgt    <= ins_pos;
        end else if (dn_issue) begin
            r_sh_ptr <= r_sh_ptr + CNT_W'(1);
            r_sh_wa  <= up_ptr_m1[IDX_W-1:0];
        end else if (up_issue) begin
            r_sh_ptr <= up_ptr_m1;
            r_sh_wa  <= r_sh_ptr[IDX_W-1:0];
        end

        // Result fields.
        if (i_cmd.decide) begin
            r_res_ok     <= i_cmd.ok;
            r_res_served <= (r_op == OP_SERVE && i_cmd.ok) ? r_head : '0;
            r_res_pref   <= (r_op == OP_QUERY && i_cmd.ok) ? r_found_cls : 1'b0;
        end
        if (i_cmd.respond) begin
            r_o_ok     <= r_res_ok;
            r_o_served <= 16'(r_res_served);
            r_o_pref   <= r_res_pref;
            r_o_occ    <= 5'(r_count);
        end
    end

    // Status towards the controller.
    assign o_stat.op        = r_op;
    assign o_stat.found     = r_found;
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.full      = (r_count == CNT_W'(DEPTH));
    assign o_stat.scan_done = (r_rd_ptr == r_count) && !r_scan_rd;
    assign o_stat.dn_done   = (r_sh_ptr == r_count) && !r_sh_rd;
    assign o_stat.up_done   = (r_sh_ptr == r_tgt) && !r_sh_rd;
    assign o_stat.out_free  = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_ok           = r_o_ok;
    assign o_served_id    = r_o_served;
    assign o_is_preferred = r_o_pref;
    assign o_occupancy    = r_o_occ;

endmodule

/* rtl/tpq_ctrl.sv */
module tpq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  tpq_pkg::t_stat i_stat,
    output tpq_pkg::t_cmd  o_cmd,
    output logic           o_in_stall
);

    import tpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_DN,
        S_SHIFT_UP,
        S_RESP
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    o_cmd.decide = 1'b1;
                    n_state      = S_RESP;
                    case (i_stat.op)
                        OP_INSERT: begin
                            o_cmd.ok = !i_stat.found && !i_stat.full;
                            if (o_cmd.ok) begin
                                o_cmd.up_start = 1'b1;
                                n_state        = S_SHIFT_UP;
                            end
                        end
                        OP_SERVE: begin
                            o_cmd.ok = !i_stat.empty;
                            if (o_cmd.ok) begin
                                o_cmd.dn_start = 1'b1;
                                n_state        = S_SHIFT_DN;
                            end
                        end
                        OP_WITHDRAW: begin
                            o_cmd.ok = i_stat.found;
                            if (o_cmd.ok) begin
                                o_cmd.dn_start = 1'b1;
                                n_state        = S_SHIFT_DN;
                            end
                        end
                        default: begin
                            o_cmd.ok = i_stat.found;
                        end
                    endcase
                end
            end
            S_SHIFT_DN: begin
                o_cmd.dn = 1'b1;
                if (i_stat.dn_done) begin
                    o_cmd.dec = 1'b1;
                    n_state   = S_RESP;
                end
            end
            S_SHIFT_UP: begin
                o_cmd.up = 1'b1;
                if (i_stat.up_done) begin
                    o_cmd.place = 1'b1;
                    n_state     = S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.respond = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

/* rtl/two_class_priority_queue.sv */
// From acceptance to result: a search over the N ids queued, through the memory's single
// read port, then, for a successful insert, serve or withdraw, a shift of the entries
// behind the changed position, one entry a cycle.
// Items: one at a time; no new item is taken until the last result is in the output register.
// Reset: synchronous, active low; the queue comes out of reset empty.
module two_class_priority_queue #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_person_id,
    input  logic        i_preferred,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_ok,
    output logic [15:0] o_served_id,
    output logic        o_is_preferred,
    output logic [4:0]  o_occupancy
);

    import tpq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    tpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    tpq_datapath #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_op),
        .i_person_id    (i_person_id),
        .i_preferred    (i_preferred),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_ok           (o_ok),
        .o_served_id    (o_served_id),
        .o_is_preferred (o_is_preferred),
        .o_occupancy    (o_occupancy)
    );

    // The queue is never reported full and empty at once.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.full && stat.empty))
        else $error("queue reported full and empty together");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("block not busy after accepting an item");

    // A failed operation reports neither a served id nor a class.
    a_fail_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_served_id == 16'd0 && !o_is_preferred))
        else $error("failed operation carries result fields");

    // A served id and a queried class never appear in the same result.
    a_fields_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_preferred && o_served_id != 16'd0))
        else $error("served id and class reported together");

    // A new result is only raised while an item is in progress.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised with no item in progress");

endmodule
